// File: rtl/gsp_pkg.sv
package gsp_pkg;

  typedef enum logic [1:0] {
    OP_SLOT   = 2'd0,
    OP_POLL   = 2'd1,
    OP_INIT   = 2'd2,
    OP_RUMBLE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    KIND_IDLE   = 2'd0,
    KIND_POLL   = 2'd1,
    KIND_INIT   = 2'd2,
    KIND_RUMBLE = 2'd3
  } kind_t;

  localparam int RX_BYTES = 9;

  localparam logic [2:0] STEP_SHORT_END = 3'd3;
  localparam logic [2:0] STEP_ENTER     = 3'd3;
  localparam logic [2:0] STEP_LOCK      = 3'd4;
  localparam logic [2:0] STEP_EXIT      = 3'd5;
  localparam logic [2:0] STEP_LAST      = 3'd5;

  localparam logic [3:0] SHORT_LEN = 4'd5;

  localparam logic [7:0] CMD_START  = 8'h01;
  localparam logic [7:0] CMD_POLL   = 8'h42;
  localparam logic [7:0] CMD_CONFIG = 8'h43;
  localparam logic [7:0] CMD_MODE   = 8'h44;
  localparam logic [7:0] CMD_ONE    = 8'h01;
  localparam logic [7:0] CMD_LOCK   = 8'h03;
  localparam logic [7:0] CMD_PAD    = 8'h5A;
  localparam logic [7:0] CMD_NONE   = 8'h00;

  localparam logic [7:0] ID_ANALOG = 8'h73;
  localparam logic [7:0] AXIS_HI   = 8'd192;
  localparam logic [7:0] AXIS_LO   = 8'd64;
  localparam logic [7:0] X_CENTRE  = 8'd127;
  localparam logic [7:0] Y_CENTRE  = 8'd128;

  typedef logic [RX_BYTES-1:0][7:0] rx_bytes_t;

  typedef struct packed {
    op_t        opcode;
    logic       data_in;
    logic [7:0] motor_small;
    logic [7:0] motor_large;
  } gsp_req_t;

  typedef struct packed {
    logic       cmd_bit;
    logic       select_active;
    logic       busy_res;
    logic       poll_done;
    logic [7:0] device_id;
    logic       analog_ok;
    logic [4:0] key_index;
    logic [7:0] right_x;
    logic [7:0] right_y;
    logic [7:0] left_x;
    logic [7:0] left_y;
  } gsp_res_t;

  typedef struct packed {
    logic cmd_bit;
    logic select_active;
    logic busy;
    logic done;
  } gsp_status_t;

  function automatic logic [7:0] tx_byte(kind_t kind, logic [2:0] step, logic [3:0] idx,
                                         logic [7:0] mot_s, logic [7:0] mot_l);
    logic [7:0] b;
    b = CMD_NONE;
    if (idx == 4'd0) begin
      b = CMD_START;
    end else if (kind == KIND_INIT) begin
      if (step == STEP_ENTER) begin
        if (idx == 4'd1) b = CMD_CONFIG;
        else if (idx == 4'd3) b = CMD_ONE;
      end else if (step == STEP_LOCK) begin
        if (idx == 4'd1) b = CMD_MODE;
        else if (idx == 4'd3) b = CMD_ONE;
        else if (idx == 4'd4) b = CMD_LOCK;
      end else if (step == STEP_EXIT) begin
        if (idx == 4'd1) b = CMD_CONFIG;
        else if (idx >= 4'd4) b = CMD_PAD;
      end else begin
        if (idx == 4'd1) b = CMD_POLL;
      end
    end else if (idx == 4'd1) begin
      b = CMD_POLL;
    end else if (kind == KIND_RUMBLE) begin
      if (idx == 4'd3) b = mot_s;
      else if (idx == 4'd4) b = mot_l;
    end
    return b;
  endfunction

endpackage

// File: rtl/gsp_frame_ctrl.sv
module gsp_frame_ctrl #(
  parameter int FRAME_BYTES = 9
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  gsp_pkg::gsp_req_t   req,
  output gsp_pkg::gsp_status_t status,
  output gsp_pkg::rx_bytes_t  bytes_nxt
);
  import gsp_pkg::*;

  localparam logic [3:0] FULL_LEN = 4'(FRAME_BYTES);

  kind_t      kind_r, kind_nxt;
  logic [2:0] step_r, step_nxt;
  logic [7:0] tx_r, tx_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [3:0] byte_r, byte_nxt;
  logic       gap_r, gap_nxt;
  logic [7:0] mot_s_r, mot_s_nxt;
  logic [7:0] mot_l_r, mot_l_nxt;
  rx_bytes_t  bytes_r;
  logic       done;
  logic [3:0] len;
  logic [3:0] byte_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_IDLE;
      step_r  <= '0;
      tx_r    <= '0;
      rx_r    <= '0;
      bit_r   <= '0;
      byte_r  <= '0;
      gap_r   <= 1'b0;
      mot_s_r <= '0;
      mot_l_r <= '0;
      bytes_r <= '0;
    end else begin
      kind_r  <= kind_nxt;
      step_r  <= step_nxt;
      tx_r    <= tx_nxt;
      rx_r    <= rx_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      gap_r   <= gap_nxt;
      mot_s_r <= mot_s_nxt;
      mot_l_r <= mot_l_nxt;
      bytes_r <= bytes_nxt;
    end
  end

  assign len      = (kind_r == KIND_INIT && step_r < STEP_SHORT_END) ? SHORT_LEN : FULL_LEN;
  assign byte_inc = byte_r + 4'd1;

  always_comb begin
    kind_nxt  = kind_r;
    step_nxt  = step_r;
    tx_nxt    = tx_r;
    rx_nxt    = rx_r;
    bit_nxt   = bit_r;
    byte_nxt  = byte_r;
    gap_nxt   = gap_r;
    mot_s_nxt = mot_s_r;
    mot_l_nxt = mot_l_r;
    bytes_nxt = bytes_r;
    done      = 1'b0;
    if (acc) begin
      if (req.opcode != OP_SLOT) begin
        if (kind_r == KIND_IDLE) begin
          kind_nxt = kind_t'(req.opcode);
          step_nxt = '0;
          if (req.opcode == OP_POLL) bytes_nxt = '0;
          if (req.opcode == OP_RUMBLE) begin
            mot_s_nxt = req.motor_small;
            mot_l_nxt = req.motor_large;
          end
          bit_nxt  = '0;
          byte_nxt = '0;
          rx_nxt   = '0;
          gap_nxt  = 1'b0;
          tx_nxt   = CMD_START;
        end
      end else if (kind_r != KIND_IDLE) begin
        if (gap_r) begin
          bit_nxt  = '0;
          byte_nxt = '0;
          rx_nxt   = '0;
          gap_nxt  = 1'b0;
          tx_nxt   = CMD_START;
        end else begin
          rx_nxt  = {req.data_in, rx_r[7:1]};
          tx_nxt  = {1'b0, tx_r[7:1]};
          bit_nxt = bit_r + 3'd1;
          if (bit_r == 3'd7) begin
            if (byte_r < 4'(RX_BYTES)) bytes_nxt[byte_r] = rx_nxt;
            byte_nxt = byte_inc;
            if (byte_inc >= len) begin
              tx_nxt = '0;
              if (kind_r == KIND_INIT && step_r < STEP_LAST) begin
                step_nxt = step_r + 3'd1;
                gap_nxt  = 1'b1;
              end else begin
                done     = (kind_r == KIND_POLL);
                kind_nxt = KIND_IDLE;
                step_nxt = '0;
              end
            end else begin
              tx_nxt = tx_byte(kind_r, step_r, byte_inc, mot_s_r, mot_l_r);
            end
          end
        end
      end
    end
  end

  always_comb begin
    status.busy          = (kind_nxt != KIND_IDLE);
    status.select_active = status.busy && !gap_nxt;
    status.cmd_bit       = status.select_active && tx_nxt[0];
    status.done          = done;
  end

endmodule

// File: rtl/gsp_report.sv
module gsp_report (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 acc,
  input  gsp_pkg::gsp_status_t status,
  input  gsp_pkg::rx_bytes_t   bytes_nxt,
  output logic                 out_valid,
  input  logic                 out_stall,
  output gsp_pkg::gsp_res_t    out_res
);
  import gsp_pkg::*;

  logic       out_valid_r, out_valid_nxt;
  gsp_res_t   res_r, res_nxt;
  logic [15:0] keys;
  logic [4:0]  key;
  logic [7:0]  rx, ry;

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  always_comb begin
    keys = {bytes_nxt[4], bytes_nxt[3]};
    key  = '0;
    for (int j = 15; j >= 0; j--) begin
      if (!keys[j]) key = 5'(j + 1);
    end
    rx = bytes_nxt[5];
    ry = bytes_nxt[6];
    if (ry > AXIS_HI || ry < AXIS_LO) rx = X_CENTRE;
    if (rx > AXIS_HI || rx < AXIS_LO) ry = Y_CENTRE;
  end

  always_comb begin
    res_nxt               = '0;
    res_nxt.cmd_bit       = status.cmd_bit;
    res_nxt.select_active = status.select_active;
    res_nxt.busy_res      = status.busy;
    if (status.done) begin
      res_nxt.poll_done = 1'b1;
      res_nxt.device_id = bytes_nxt[1];
      res_nxt.analog_ok = (bytes_nxt[1] == ID_ANALOG);
      res_nxt.key_index = key;
      res_nxt.right_x   = rx;
      res_nxt.right_y   = ry;
      res_nxt.left_x    = bytes_nxt[7];
      res_nxt.left_y    = bytes_nxt[8];
    end
    out_valid_nxt = acc || in_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

// File: rtl/gamepad_serial_poll_engine.sv
// Gamepad serial link master. Each request is a bit slot or a frame start (poll, rumble or
// the six-frame init sequence); each yields one result in the cycle after acceptance, from a
// single result register fed by the frame shifters, counters and the report logic. A new
// request is accepted every cycle while the result register is empty or being taken;
// a held result stalls the input only for as long as it is held. Poll reports (device id,
// analog flag, first pressed button, stick bytes) appear on the slot that ends a poll frame.
module gamepad_serial_poll_engine #(
  parameter int FRAME_BYTES = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gsp_pkg::gsp_req_t in_req,
  output logic              out_valid,
  input  logic              out_stall,
  output gsp_pkg::gsp_res_t out_res
);
  import gsp_pkg::*;

  logic        acc;
  gsp_status_t status;
  rx_bytes_t   bytes_nxt;

  gsp_frame_ctrl #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .req      (in_req),
    .status   (status),
    .bytes_nxt(bytes_nxt)
  );

  gsp_report u_report (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .acc      (acc),
    .status   (status),
    .bytes_nxt(bytes_nxt),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res  (out_res)
  );

endmodule

// File: dv/gamepad_serial_poll_engine_tb.sv
`timescale 1ns / 100ps

module gamepad_serial_poll_engine_tb;
  import gsp_pkg::*;

  localparam logic [3:0] FRAME_LEN = 4'd9;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int STIM_TARGET = 1900;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    gsp_req_t req;
    bit       drain_first;
  } queued_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  gsp_req_t in_req = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  gsp_res_t out_res;

  queued_req_t pending_reqs[$];
  gsp_res_t link_results[$];

  int cycle_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  int error_count = 0;
  int results_seen = 0;
  int frame_items = 0;
  int polls_reported = 0;
  int inits_started = 0;
  int rumbles_started = 0;
  int ignored_reqs = 0;

  // link state
  logic [7:0] tx_sh;
  logic [7:0] rx_sh;
  logic [2:0] bit_cnt;
  logic [3:0] byte_cnt;
  logic [2:0] init_step;
  kind_t      link_kind;
  logic [7:0] motor_s;
  logic [7:0] motor_l;
  logic [7:0] pad_bytes [RX_BYTES];
  logic       cs_gap;

  gamepad_serial_poll_engine #(
    .FRAME_BYTES(FRAME_LEN)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req(in_req),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_res(out_res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [3:0] frame_bytes();
    if (link_kind == KIND_INIT && init_step < STEP_SHORT_END) return SHORT_LEN;
    return FRAME_LEN;
  endfunction

  function automatic logic [7:0] command_byte(logic [3:0] idx);
    logic [7:0] b;
    b = CMD_NONE;
    if (idx == 4'd0) begin
      b = CMD_START;
    end else if (link_kind == KIND_INIT) begin
      case (init_step)
        STEP_ENTER: begin
          if (idx == 4'd1) b = CMD_CONFIG;
          if (idx == 4'd3) b = CMD_ONE;
        end
        STEP_LOCK: begin
          if (idx == 4'd1) b = CMD_MODE;
          if (idx == 4'd3) b = CMD_ONE;
          if (idx == 4'd4) b = CMD_LOCK;
        end
        STEP_EXIT: begin
          if (idx == 4'd1) b = CMD_CONFIG;
          if (idx >= 4'd4) b = CMD_PAD;
        end
        default: begin
          if (idx == 4'd1) b = CMD_POLL;
        end
      endcase
    end else if (idx == 4'd1) begin
      b = CMD_POLL;
    end else if (link_kind == KIND_RUMBLE && idx == 4'd3) begin
      b = motor_s;
    end else if (link_kind == KIND_RUMBLE && idx == 4'd4) begin
      b = motor_l;
    end
    return b;
  endfunction

  function automatic void open_frame();
    bit_cnt = '0;
    byte_cnt = '0;
    rx_sh = '0;
    cs_gap = 1'b0;
    tx_sh = command_byte(4'd0);
  endfunction

  function automatic void reset_link();
    tx_sh = '0;
    rx_sh = '0;
    bit_cnt = '0;
    byte_cnt = '0;
    init_step = '0;
    link_kind = KIND_IDLE;
    motor_s = '0;
    motor_l = '0;
    cs_gap = 1'b0;
    for (int i = 0; i < RX_BYTES; i++) pad_bytes[i] = '0;
  endfunction

  function automatic gsp_res_t advance_link(gsp_req_t r);
    gsp_res_t res;
    logic done;
    logic [15:0] keys;
    logic [7:0] rx;
    logic [7:0] ry;
    logic found;
    done = 1'b0;
    res = '0;
    if (r.opcode != OP_SLOT) begin
      if (link_kind == KIND_IDLE) begin
        link_kind = kind_t'(r.opcode);
        init_step = '0;
        if (r.opcode == OP_POLL) begin
          for (int i = 0; i < RX_BYTES; i++) pad_bytes[i] = '0;
        end
        if (r.opcode == OP_INIT) inits_started++;
        if (r.opcode == OP_RUMBLE) begin
          motor_s = r.motor_small;
          motor_l = r.motor_large;
          rumbles_started++;
        end
        open_frame();
      end else begin
        ignored_reqs++;
      end
    end else if (link_kind == KIND_IDLE) begin
      ignored_reqs++;
    end else if (cs_gap) begin
      open_frame();
    end else begin
      rx_sh = {r.data_in, rx_sh[7:1]};
      tx_sh = tx_sh >> 1;
      bit_cnt = bit_cnt + 3'd1;
      if (bit_cnt == 3'd0) begin
        if (byte_cnt < RX_BYTES) pad_bytes[byte_cnt] = rx_sh;
        byte_cnt = byte_cnt + 4'd1;
        if (byte_cnt >= frame_bytes()) begin
          if (link_kind == KIND_INIT && init_step < STEP_LAST) begin
            init_step = init_step + 3'd1;
            cs_gap = 1'b1;
          end else begin
            done = (link_kind == KIND_POLL);
            link_kind = KIND_IDLE;
            init_step = '0;
          end
          tx_sh = '0;
        end else begin
          tx_sh = command_byte(byte_cnt);
        end
      end
    end

    res.busy_res = (link_kind != KIND_IDLE);
    res.select_active = res.busy_res && !cs_gap;
    res.cmd_bit = res.select_active ? tx_sh[0] : 1'b0;
    if (done) begin
      polls_reported++;
      keys = {pad_bytes[4], pad_bytes[3]};
      found = 1'b0;
      for (int j = 0; j < 16; j++) begin
        if (!found && !keys[j]) begin
          res.key_index = 5'(j + 1);
          found = 1'b1;
        end
      end
      rx = pad_bytes[5];
      ry = pad_bytes[6];
      if (ry > AXIS_HI || ry < AXIS_LO) rx = X_CENTRE;
      if (rx > AXIS_HI || rx < AXIS_LO) ry = Y_CENTRE;
      res.poll_done = 1'b1;
      res.device_id = pad_bytes[1];
      res.analog_ok = (pad_bytes[1] == ID_ANALOG);
      res.right_x = rx;
      res.right_y = ry;
      res.left_x = pad_bytes[7];
      res.left_y = pad_bytes[8];
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < MAX_REPORTS)
      $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h", results_seen, what, got, want);
    error_count++;
  endtask

  task automatic check_result(gsp_res_t got);
    gsp_res_t want;
    if (link_results.size() == 0) begin
      report_mismatch("unexpected result", got, 0);
    end else begin
      want = link_results.pop_front();
      if (got.cmd_bit !== want.cmd_bit) report_mismatch("cmd_bit", got.cmd_bit, want.cmd_bit);
      if (got.select_active !== want.select_active)
        report_mismatch("select_active", got.select_active, want.select_active);
      if (got.busy_res !== want.busy_res) report_mismatch("busy_res", got.busy_res, want.busy_res);
      if (got.poll_done !== want.poll_done)
        report_mismatch("poll_done", got.poll_done, want.poll_done);
      if (got.device_id !== want.device_id)
        report_mismatch("device_id", got.device_id, want.device_id);
      if (got.analog_ok !== want.analog_ok)
        report_mismatch("analog_ok", got.analog_ok, want.analog_ok);
      if (got.key_index !== want.key_index)
        report_mismatch("key_index", got.key_index, want.key_index);
      if (got.right_x !== want.right_x) report_mismatch("right_x", got.right_x, want.right_x);
      if (got.right_y !== want.right_y) report_mismatch("right_y", got.right_y, want.right_y);
      if (got.left_x !== want.left_x) report_mismatch("left_x", got.left_x, want.left_x);
      if (got.left_y !== want.left_y) report_mismatch("left_y", got.left_y, want.left_y);
    end
    results_seen++;
  endtask

  function automatic int pick_gap();
    int r;
    if ((cycle_count / 128) % 4 == 0) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_req(op_t op, logic din, bit drain);
    queued_req_t q;
    q.req.opcode = op;
    q.req.data_in = din;
    q.req.motor_small = 8'($urandom);
    q.req.motor_large = 8'($urandom);
    q.drain_first = drain;
    pending_reqs.push_back(q);
  endtask

  task automatic queue_rumble(logic [7:0] ms, logic [7:0] ml);
    queued_req_t q;
    q.req.opcode = OP_RUMBLE;
    q.req.data_in = 1'($urandom);
    q.req.motor_small = ms;
    q.req.motor_large = ml;
    q.drain_first = 1'b0;
    pending_reqs.push_back(q);
    frame_items++;
  endtask

  task automatic queue_slots(rx_bytes_t resp, int nbytes, int noise_pct);
    for (int b = 0; b < nbytes; b++) begin
      for (int i = 0; i < 8; i++) begin
        queue_req(OP_SLOT, resp[b][i], 1'b0);
        frame_items++;
        if ($urandom_range(0, 99) < noise_pct)
          queue_req(op_t'($urandom_range(1, 3)), 1'($urandom), 1'b0);
      end
    end
  endtask

  function automatic rx_bytes_t pad_reply(logic [7:0] id, logic [15:0] keys, logic [7:0] rx,
                                          logic [7:0] ry, logic [7:0] lx, logic [7:0] ly);
    rx_bytes_t r;
    r[0] = 8'($urandom);
    r[1] = id;
    r[2] = ($urandom_range(0, 3) == 0) ? 8'($urandom) : CMD_PAD;
    r[3] = keys[7:0];
    r[4] = keys[15:8];
    r[5] = rx;
    r[6] = ry;
    r[7] = lx;
    r[8] = ly;
    return r;
  endfunction

  function automatic logic [7:0] pick_axis();
    case ($urandom_range(0, 11))
      0: return 8'd0;
      1: return 8'd63;
      2: return AXIS_LO;
      3: return 8'd65;
      4: return X_CENTRE;
      5: return Y_CENTRE;
      6: return 8'd191;
      7: return AXIS_HI;
      8: return 8'd193;
      9: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_keys();
    case ($urandom_range(0, 3))
      0: return 16'hFFFF;
      1: return ~(16'h1 << $urandom_range(0, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_id();
    case ($urandom_range(0, 9))
      0: return 8'h41;
      1, 2: return 8'($urandom);
      default: return ID_ANALOG;
    endcase
  endfunction

  function automatic rx_bytes_t random_reply();
    return pad_reply(pick_id(), pick_keys(), pick_axis(), pick_axis(), pick_axis(), pick_axis());
  endfunction

  task automatic queue_poll(rx_bytes_t resp, int noise_pct, bit drain);
    queue_req(OP_POLL, 1'($urandom), drain);
    frame_items++;
    queue_slots(resp, FRAME_LEN, noise_pct);
  endtask

  task automatic queue_init(int noise_pct);
    queue_req(OP_INIT, 1'($urandom), 1'b0);
    frame_items++;
    for (int f = 0; f <= STEP_LAST; f++) begin
      if (f != 0) begin
        queue_req(OP_SLOT, 1'($urandom), 1'b0);
        frame_items++;
      end
      queue_slots(random_reply(), (f < STEP_SHORT_END) ? SHORT_LEN : FRAME_LEN, noise_pct);
    end
  endtask

  task automatic build_stimulus();
    int pick;
    bit drain;
    // directed: idle slots, suppression corners, key extremes, every frame kind
    queue_req(OP_SLOT, 1'b0, 1'b0);
    queue_req(OP_SLOT, 1'b1, 1'b0);
    queue_poll(pad_reply(ID_ANALOG, 16'hFFFF, 8'd200, 8'd100, 8'h00, 8'hFF), 3, 1'b0);
    queue_poll(pad_reply(8'h41, 16'h7FFF, 8'd30, 8'd63, 8'hFF, 8'h00), 0, 1'b0);
    queue_poll(pad_reply(8'hFF, 16'hFFFE, 8'd0, 8'd255, 8'd64, 8'd192), 0, 1'b0);
    queue_poll(pad_reply(8'h00, 16'h0000, 8'd192, 8'd64, 8'd127, 8'd128), 0, 1'b0);
    queue_rumble(8'hFF, 8'h00);
    queue_slots(random_reply(), FRAME_LEN, 0);
    queue_rumble(8'h00, 8'hFF);
    queue_slots(random_reply(), FRAME_LEN, 3);
    queue_init(2);
    queue_poll(random_reply(), 0, 1'b0);

    // random: mostly well-formed frames, some noise
    drain = 1'b1;
    while (frame_items < STIM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        queue_poll(random_reply(), ($urandom_range(0, 4) == 0) ? 2 : 0, drain);
        drain = 1'b0;
      end else if (pick < 80) begin
        queue_rumble(8'($urandom), 8'($urandom));
        queue_slots(random_reply(), FRAME_LEN, ($urandom_range(0, 4) == 0) ? 2 : 0);
      end else if (pick < 88) begin
        queue_init(($urandom_range(0, 4) == 0) ? 1 : 0);
      end else begin
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 99) < 85) queue_req(OP_SLOT, 1'($urandom), 1'b0);
          else queue_req(op_t'($urandom_range(0, 3)), 1'($urandom), 1'b0);
        end
      end
      if (frame_items > STIM_TARGET / 2 && frame_items < STIM_TARGET / 2 + 80) drain = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TIMEOUT after %0d cycles, %0d results outstanding", cycle_count,
               link_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // request side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) link_results.push_back(advance_link(in_req));
      if (!in_valid || !in_stall) begin
        if (send_gap != 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     (!pending_reqs[0].drain_first || link_results.size() == 0)) begin
          in_req <= pending_reqs[0].req;
          in_valid <= 1'b1;
          void'(pending_reqs.pop_front());
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) check_result(out_res);
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= pick_gap();
      end
    end
  end

  initial begin
    reset_link();
    build_stimulus();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_reqs.size() != 0 || in_valid) @(negedge clk);
    while (link_results.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    while (link_results.size() != 0) begin
      report_mismatch("missing result", 0, link_results[0]);
      void'(link_results.pop_front());
    end
    $display("Checked %0d results: %0d poll reports, %0d init sequences, %0d rumble frames,",
             results_seen, polls_reported, inits_started, rumbles_started);
    $display("%0d ignored requests, %0d mismatches", ignored_reqs, error_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/gsp_pkg.sv
rtl/gsp_frame_ctrl.sv
rtl/gsp_report.sv
rtl/gamepad_serial_poll_engine.sv
dv/gamepad_serial_poll_engine_tb.sv
